// ===== hw/rtl/sao_pkg.sv =====
// Shared types and constants of the sprite alpha outline block.
// No dependencies; imported by sao_cfg, sprite_alpha_outline and the testbench.
package sao_pkg;

    localparam int DEF_MAX_IMAGE_WIDTH = 256;
    localparam int DEF_MAX_EDGE_RADIUS = 8;
    localparam int HEIGHT_LIMIT        = 256;
    localparam int PADDR_W             = 5;
    localparam int PDATA_W             = 32;

    typedef enum logic [2:0] {
        REG_EDGE_WIDTH    = 3'd0,
        REG_OPAQUE_LEVEL  = 3'd1,
        REG_OUTLINE_RED   = 3'd2,
        REG_OUTLINE_GREEN = 3'd3,
        REG_OUTLINE_BLUE  = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_IMAGE_HEIGHT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [3:0] edge_width;
        logic [7:0] opaque_level;
        logic [7:0] outline_red;
        logic [7:0] outline_green;
        logic [7:0] outline_blue;
        logic [8:0] image_width;
        logic [8:0] image_height;
    } t_cfg;

endpackage

// ===== hw/rtl/sprite_alpha_outline.sv =====
// Top level of the sprite alpha outline block: delay line, window runs, output.
// Depends on sao_pkg, sao_cfg and sao_ram.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   input    | i_valid / o_stall          | i_operation, i_red..i_alpha
//   output   | o_valid / i_stall          | o_out_red..o_out_alpha, o_frame_end
//   config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// One word per cycle unless stalled; results go via stage and output registers.
// Throughput is set by the single read/write pass over the delay and column RAMs.
// A stalled output register holds the whole pipeline and raises o_stall.
// Reset is synchronous; the RAMs need no clearing pass.
module sprite_alpha_outline #(
    parameter int MAX_IMAGE_WIDTH = sao_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_EDGE_RADIUS = sao_pkg::DEF_MAX_EDGE_RADIUS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    input  logic [7:0]                  i_alpha,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_out_red,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_blue,
    output logic [7:0]                  o_out_alpha,
    output logic                        o_frame_end,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sao_pkg::PADDR_W-1:0] paddr,
    input  logic [sao_pkg::PDATA_W-1:0] pwdata,
    output logic [sao_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import sao_pkg::*;

    localparam int DEPTH = MAX_EDGE_RADIUS * MAX_IMAGE_WIDTH + MAX_EDGE_RADIUS;
    localparam int DA    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = $clog2(MAX_IMAGE_WIDTH);
    localparam int WV    = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int RW    = $clog2(MAX_EDGE_RADIUS + 1);
    localparam int VW    = $clog2(2 * MAX_EDGE_RADIUS + 2);
    localparam int YW    = $clog2(HEIGHT_LIMIT);
    localparam int HV    = $clog2(HEIGHT_LIMIT + 1);

    t_cfg cfg;
    logic restart;

    sao_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    logic [RW-1:0] rad;
    logic [WV-1:0] wid;
    logic [HV-1:0] hgt;
    logic [CW-1:0] lag;
    logic [VW-1:0] span;

    assign rad = ({28'd0, cfg.edge_width} > 32'(MAX_EDGE_RADIUS)) ?
                 RW'(MAX_EDGE_RADIUS) : RW'(cfg.edge_width);
    assign wid = (cfg.image_width == 9'd0) ? WV'(1) :
                 ({23'd0, cfg.image_width} > 32'(MAX_IMAGE_WIDTH)) ?
                 WV'(MAX_IMAGE_WIDTH) : WV'(cfg.image_width);
    assign hgt = (cfg.image_height == 9'd0) ? HV'(1) :
                 ({23'd0, cfg.image_height} > 32'(HEIGHT_LIMIT)) ?
                 HV'(HEIGHT_LIMIT) : HV'(cfg.image_height);
    assign lag  = CW'(32'(rad) * 32'(wid) + 32'(rad));
    assign span = VW'({rad, 1'b1});

    logic en, acc, lag0, pop, push, send_a;

    logic [XW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [YW-1:0] r_in_line, n_in_line, r_out_line, n_out_line;
    logic [DA-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          r_s_v, r_s_flush, r_s_send, r_s_lag0;
    logic [31:0]   r_s_px;
    logic [XW-1:0] r_s_x;
    logic [YW-1:0] r_s_y;
    logic          r_fw_hit;
    logic [VW-1:0] r_fw_val;
    logic [VW-1:0] r_hrun, n_hrun;

    logic          r_ov;
    logic [31:0]   r_opx;
    logic          r_ofe;

    logic [31:0]   fifo_rdata;
    logic [VW-1:0] vrun_rdata, vold, vnew;
    logic          vwe, full, opq_in, opq_out, border, bnd, send_b, fe;
    logic [31:0]   spx;

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;
    assign acc     = i_valid && en;
    assign lag0    = (lag == '0);
    assign send_a  = i_operation ? (r_count != '0) : (lag0 || (r_count >= lag));
    assign pop     = acc && !lag0 && send_a;
    assign push    = acc && !i_operation && !lag0;

    sao_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_delay (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata ({i_alpha, i_blue, i_green, i_red}),
        .i_re    (en),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    sao_ram #(.WIDTH(VW), .DEPTH(MAX_IMAGE_WIDTH)) u_vrun (
        .i_clk   (i_clk),
        .i_we    (vwe),
        .i_waddr (r_s_x),
        .i_wdata (vnew),
        .i_re    (en),
        .i_raddr (r_in_col),
        .o_rdata (vrun_rdata)
    );

    // vertical and horizontal opaque runs of the arriving pixel
    assign vwe    = en && r_s_v && !r_s_flush;
    assign opq_in = (r_s_px[31:24] >= cfg.opaque_level);
    assign vold   = r_fw_hit ? r_fw_val : vrun_rdata;
    assign vnew   = !opq_in ? '0 : (r_s_y == '0) ? VW'(1) :
                    (vold >= span) ? span : vold + VW'(1);
    assign n_hrun = (vnew != span) ? '0 : (r_s_x == '0) ? VW'(1) :
                    (r_hrun >= span) ? span : r_hrun + VW'(1);
    assign full   = (n_hrun == span);

    // leaving pixel
    assign send_b  = r_s_v && r_s_send;
    assign spx     = r_s_lag0 ? r_s_px : fifo_rdata;
    assign opq_out = (spx[31:24] >= cfg.opaque_level);
    assign border  = (32'(r_out_col) < 32'(rad)) || (32'(r_out_line) < 32'(rad)) ||
                     (32'(r_out_col) + 32'(rad) >= 32'(wid)) ||
                     (32'(r_out_line) + 32'(rad) >= 32'(hgt));
    assign bnd     = !r_s_lag0 && opq_out && (r_s_flush || border || !full);
    assign fe      = (32'(r_out_line) == 32'(hgt) - 32'd1) &&
                     (32'(r_out_col) == 32'(wid) - 32'd1);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_line = r_in_line;
        if (acc && !i_operation) begin
            if (32'(r_in_col) + 32'd1 >= 32'(wid)) begin
                n_in_col = '0;
                n_in_line = (32'(r_in_line) + 32'd1 >= 32'(hgt)) ? '0 :
                            r_in_line + YW'(1);
            end else begin
                n_in_col = r_in_col + XW'(1);
            end
        end
        n_out_col  = r_out_col;
        n_out_line = r_out_line;
        if (en && send_b) begin
            if (32'(r_out_col) + 32'd1 >= 32'(wid)) begin
                n_out_col = '0;
                n_out_line = (32'(r_out_line) + 32'd1 >= 32'(hgt)) ? '0 :
                             r_out_line + YW'(1);
            end else begin
                n_out_col = r_out_col + XW'(1);
            end
        end
        n_head  = pop  ? ((32'(r_head) == DEPTH - 1) ? '0 : r_head + DA'(1)) : r_head;
        n_tail  = push ? ((32'(r_tail) == DEPTH - 1) ? '0 : r_tail + DA'(1)) : r_tail;
        n_count = r_count + CW'(push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_in_col   <= '0;
            r_in_line  <= '0;
            r_out_col  <= '0;
            r_out_line <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_line  <= n_in_line;
            r_out_col  <= n_out_col;
            r_out_line <= n_out_line;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v    <= 1'b0;
            r_fw_hit <= 1'b0;
            r_ov     <= 1'b0;
        end else if (en) begin
            r_s_v    <= acc;
            r_fw_hit <= vwe && (r_s_x == r_in_col);
            r_ov     <= send_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_flush <= i_operation;
            r_s_send  <= send_a;
            r_s_lag0  <= lag0;
            r_s_px    <= {i_alpha, i_blue, i_green, i_red};
            r_s_x     <= r_in_col;
            r_s_y     <= r_in_line;
            r_fw_val  <= vnew;
            if (vwe) begin
                r_hrun <= n_hrun;
            end
            if (send_b) begin
                r_opx <= bnd ? {spx[31:24], cfg.outline_blue, cfg.outline_green,
                                cfg.outline_red} : spx;
                r_ofe <= fe;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_out_red   = r_opx[7:0];
    assign o_out_green = r_opx[15:8];
    assign o_out_blue  = r_opx[23:16];
    assign o_out_alpha = r_opx[31:24];
    assign o_frame_end = r_ofe;
endmodule

// ===== hw/rtl/sao_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sao_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sao_cfg.sv =====
// APB configuration registers of the sprite alpha outline block.
// Depends on sao_pkg.
module sao_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sao_pkg::PADDR_W-1:0] paddr,
    input  logic [sao_pkg::PDATA_W-1:0] pwdata,
    output logic [sao_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output sao_pkg::t_cfg               o_cfg,
    output logic                        o_restart
);
    import sao_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     n_restart;
    logic     wr;
    t_reg_idx idx;

    assign wr  = psel && penable && pwrite;
    assign idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        n_cfg     = r_cfg;
        n_restart = 1'b0;
        if (wr) begin
            case (idx)
                REG_EDGE_WIDTH: begin
                    n_cfg.edge_width = pwdata[3:0];
                    n_restart = 1'b1;
                end
                REG_OPAQUE_LEVEL: begin
                    n_cfg.opaque_level = pwdata[7:0];
                    n_restart = 1'b1;
                end
                REG_OUTLINE_RED:   n_cfg.outline_red   = pwdata[7:0];
                REG_OUTLINE_GREEN: n_cfg.outline_green = pwdata[7:0];
                REG_OUTLINE_BLUE:  n_cfg.outline_blue  = pwdata[7:0];
                REG_IMAGE_WIDTH: begin
                    n_cfg.image_width = pwdata[8:0];
                    n_restart = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    n_cfg.image_height = pwdata[8:0];
                    n_restart = 1'b1;
                end
                default: n_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_width    <= 4'd0;
            r_cfg.opaque_level  <= 8'd1;
            r_cfg.outline_red   <= 8'd0;
            r_cfg.outline_green <= 8'd0;
            r_cfg.outline_blue  <= 8'd0;
            r_cfg.image_width   <= 9'd256;
            r_cfg.image_height  <= 9'd256;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_EDGE_WIDTH:    prdata = {28'd0, r_cfg.edge_width};
            REG_OPAQUE_LEVEL:  prdata = {24'd0, r_cfg.opaque_level};
            REG_OUTLINE_RED:   prdata = {24'd0, r_cfg.outline_red};
            REG_OUTLINE_GREEN: prdata = {24'd0, r_cfg.outline_green};
            REG_OUTLINE_BLUE:  prdata = {24'd0, r_cfg.outline_blue};
            REG_IMAGE_WIDTH:   prdata = {23'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {23'd0, r_cfg.image_height};
            default:           prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;
    assign o_restart = n_restart;
endmodule

// ===== tb/sprite_alpha_outline_tb.sv =====
// Self-checking testbench for sprite_alpha_outline: a scoreboard class predicts
// each outlined pixel from its own copy of the window state. Depends on sao_pkg and sprite_alpha_outline.
module sprite_alpha_outline_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sao_pkg::*;

    localparam bit OP_PIXEL = 1'b0;
    localparam bit OP_FLUSH = 1'b1;
    localparam int ROWS     = 2 * DEF_MAX_EDGE_RADIUS + 1;
    localparam int MAX_CYC  = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } t_pix_out;

    class outline_scoreboard;
        logic [3:0]  edge_w;
        logic [7:0]  thr, col_r, col_g, col_b;
        logic [8:0]  img_w, img_h;
        logic [31:0] held_q[$];
        bit          opq[ROWS * DEF_MAX_IMAGE_WIDTH];
        int          in_col, in_ln, out_col, out_ln;
        t_pix_out    expect_q[$];
        int          errors;

        function new();
            edge_w = 4'd0; thr = 8'd1; col_r = 8'd0; col_g = 8'd0; col_b = 8'd0;
            img_w = 9'd256; img_h = 9'd256; errors = 0;
            foreach (opq[k]) opq[k] = 1'b0;
            restart();
        endfunction

        function void restart();
            in_col = 0; in_ln = 0; out_col = 0; out_ln = 0;
            held_q.delete();
        endfunction

        function int rad();
            return edge_w > DEF_MAX_EDGE_RADIUS ? DEF_MAX_EDGE_RADIUS : int'(edge_w);
        endfunction

        function int fw();
            if (img_w == 0) return 1;
            return img_w > DEF_MAX_IMAGE_WIDTH ? DEF_MAX_IMAGE_WIDTH : int'(img_w);
        endfunction

        function int fh();
            if (img_h == 0) return 1;
            return img_h > HEIGHT_LIMIT ? HEIGHT_LIMIT : int'(img_h);
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_EDGE_WIDTH: begin
                    edge_w = val[3:0]; restart();
                end
                REG_OPAQUE_LEVEL: begin
                    thr = val[7:0]; restart();
                end
                REG_OUTLINE_RED:   col_r = val[7:0];
                REG_OUTLINE_GREEN: col_g = val[7:0];
                REG_OUTLINE_BLUE:  col_b = val[7:0];
                REG_IMAGE_WIDTH: begin
                    img_w = val[8:0]; restart();
                end
                REG_IMAGE_HEIGHT: begin
                    img_h = val[8:0]; restart();
                end
                default: ;
            endcase
        endfunction

        function bit on_boundary(int y, int x, int r, int w, int h, int held);
            int nxt;
            bit wrapped;
            if (x < r || y < r || x + r >= w || y + r >= h) return 1;
            nxt = in_ln * w + in_col;
            wrapped = (y * w + x + held) != nxt;
            for (int ny = y - r; ny <= y + r; ny++)
                for (int nx = x - r; nx <= x + r; nx++) begin
                    if (!wrapped && ny * w + nx >= nxt) return 1;
                    if (!opq[(ny % ROWS) * DEF_MAX_IMAGE_WIDTH + nx]) return 1;
                end
            return 0;
        endfunction

        function void emit(logic [31:0] px, int held);
            t_pix_out o;
            int w, h;
            w = fw(); h = fh();
            o.red = px[7:0]; o.green = px[15:8]; o.blue = px[23:16]; o.alpha = px[31:24];
            if (rad() > 0 && o.alpha >= thr &&
                on_boundary(out_ln, out_col, rad(), w, h, held)) begin
                o.red = col_r; o.green = col_g; o.blue = col_b;
            end
            o.frame_end = (out_ln == h - 1 && out_col == w - 1);
            if (++out_col >= w) begin
                out_col = 0;
                if (++out_ln >= h) out_ln = 0;
            end
            expect_q.push_back(o);
        endfunction

        function void note_word(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] a);
            logic [31:0] px, oldest;
            int lag;
            lag = rad() * fw() + rad();
            if (op == OP_FLUSH) begin
                if (held_q.size() == 0) return;
                oldest = held_q.pop_front();
                emit(oldest, held_q.size() + 1);
                return;
            end
            px = {a, b, g, r};
            opq[(in_ln % ROWS) * DEF_MAX_IMAGE_WIDTH + in_col] = (a >= thr);
            if (++in_col >= fw()) begin
                in_col = 0;
                if (++in_ln >= fh()) in_ln = 0;
            end
            if (lag == 0) begin
                emit(px, 1);
            end else if (held_q.size() >= lag) begin
                oldest = held_q.pop_front();
                held_q.push_back(px);
                emit(oldest, held_q.size() + 1);
            end else begin
                held_q.push_back(px);
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_pix_out got);
            t_pix_out want;
            if (expect_q.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            want = expect_q.pop_front();
            if (got.red !== want.red) report("red", int'(got.red), int'(want.red));
            if (got.green !== want.green)
                report("green", int'(got.green), int'(want.green));
            if (got.blue !== want.blue) report("blue", int'(got.blue), int'(want.blue));
            if (got.alpha !== want.alpha)
                report("alpha", int'(got.alpha), int'(want.alpha));
            if (got.frame_end !== want.frame_end)
                report("frame_end", int'(got.frame_end), int'(want.frame_end));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic [7:0]         i_red = '0, i_green = '0, i_blue = '0, i_alpha = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic               o_frame_end;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    outline_scoreboard sb = new();
    int  cycles = 0;
    int  words_sent = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    sprite_alpha_outline DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_out_red, o_out_green, o_out_blue, o_out_alpha, o_frame_end});

    always @(negedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PADDR_W'(int'(idx) * 4); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // call at a falling edge; returns at the falling edge after the accept
    task send_word(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_operation = op; i_red = r; i_green = g; i_blue = b; i_alpha = a;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(op, r, g, b, a);
        words_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task wait_drained();
        while (sb.expect_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task settle();
        wait_drained();
        repeat (8) @(posedge i_clk);
    endtask

    task send_pixel();
        logic [7:0] a;
        if (sb.thr != 0 && $urandom_range(0, 3) == 0) a = 8'($urandom_range(0, sb.thr - 1));
        else a = 8'($urandom_range(sb.thr, 255));
        send_word(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), a);
    endtask

    task send_flush();
        send_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task configure(int e, int t, int w, int h);
        write_reg(REG_OUTLINE_RED, $urandom_range(0, 255));
        write_reg(REG_OUTLINE_GREEN, $urandom_range(0, 255));
        write_reg(REG_OUTLINE_BLUE, $urandom_range(0, 255));
        write_reg(REG_EDGE_WIDTH, e);
        write_reg(REG_OPAQUE_LEVEL, t);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        int phase, e, t, w, h, n, sel;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pass-through at reset values, flush with nothing held
        send_word(OP_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_word(OP_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        send_word(OP_PIXEL, 8'h5A, 8'hA5, 8'h3C, 8'h01);
        send_word(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        settle();

        configure(1, 128, 3, 3);
        send_word(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_word(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd128);
        send_word(OP_PIXEL, 8'h11, 8'h22, 8'h33, 8'd127);
        repeat (6) send_word(OP_PIXEL, 8'hAA, 8'h55, 8'hC3, 8'hFF);
        repeat (5) send_word(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        // oversized radius and out-of-range geometry
        configure(15, 0, 0, 0);
        send_word(OP_PIXEL, 8'h12, 8'h34, 8'h56, 8'h00);
        send_word(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        phase = 0;
        while (words_sent < 1150) begin
            if (words_sent > 1000) quiet = 1'b1;
            e = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            sel = $urandom_range(0, 3);
            t = sel == 0 ? 0 : sel == 1 ? 255 : $urandom_range(1, 254);
            sel = $urandom_range(0, 11);
            if (quiet && sel < 2) sel = 2;
            if (sel == 0) begin
                w = 0;
                h = $urandom_range(1, 10);
            end else if (sel == 1) begin
                w = $urandom_range(256, 511);
                h = $urandom_range(1, 2);
                e = $urandom_range(0, 1);
            end else begin
                w = $urandom_range(1, 12);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                                 : $urandom_range(1, 20);
            end
            configure(e, t, w, h);
            n = sb.fw() * (sb.fh() > 30 ? 30 : sb.fh());
            sel = $urandom_range(0, 5);
            if (sel == 0) n = n / 2 + 1;
            else if (sel == 1) n = n + n / 2;
            if (n > 600) n = 600;
            if (n > 1150 - words_sent) n = 1150 - words_sent;
            for (int k = 0; k < n; k++) begin
                if (phase == 0 && k == n / 2) wait_drained();
                if ($urandom_range(0, 40) == 0) send_flush();
                send_pixel();
            end
            sel = $urandom_range(0, 7);
            if (sel != 0) begin
                n = sb.held_q.size() + $urandom_range(0, 2);
                repeat (n) send_flush();
            end
            settle();
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/sao_pkg.sv
hw/rtl/sao_ram.sv
hw/rtl/sao_cfg.sv
hw/rtl/sprite_alpha_outline.sv
tb/sprite_alpha_outline_tb.sv
